// File: hw/rtl/adsr_pkg.sv
// Shared types, constants and widths for the ADSR envelope generator.
package adsr_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int DUR_W          = 24;
    localparam int LVL_W          = 16;
    localparam int PROD_W         = DUR_W + LVL_W;
    localparam int QUO_W          = 16;
    localparam int CMD_W          = 2;
    localparam int PHASE_W        = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;

    localparam logic [CMD_W-1:0] CMD_SAMPLE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd2;

    localparam logic [PHASE_W-1:0] PHASE_ATTACK  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_DECAY   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_SUSTAIN = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_RELEASE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd4;

    localparam logic [DUR_W-1:0] RST_ATTACK  = 24'd441;
    localparam logic [DUR_W-1:0] RST_DECAY   = 24'd44100;
    localparam logic [DUR_W-1:0] RST_RELEASE = 24'd44100;
    localparam logic [LVL_W-1:0] RST_START   = 16'd32768;
    localparam logic [LVL_W-1:0] RST_SUSTAIN = 16'd0;

    localparam logic [LVL_W-1:0] FULL_LEVEL  = 16'd32768;
    localparam logic [LVL_W-1:0] FLOOR_LEVEL = 16'd3;

    typedef struct packed {
        logic [DUR_W-1:0] atk_ticks;
        logic [DUR_W-1:0] dec_ticks;
        logic [DUR_W-1:0] rel_ticks;
        logic [LVL_W-1:0] start_lvl;
        logic [LVL_W-1:0] sus_lvl;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DUR_W-1:0] x;
        logic [LVL_W-1:0] y;
        logic [DUR_W-1:0] div;
    } t_md_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_md_rsp;

endpackage

// File: hw/rtl/adsr_in_if.sv
// Request channel: command and time stamp.
interface adsr_in_if #(
    parameter int TIME_WIDTH = adsr_pkg::TIME_WIDTH_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic [adsr_pkg::CMD_W-1:0]  cmd;
    logic [TIME_WIDTH-1:0]       time_ticks;

    modport source (output valid, cmd, time_ticks, input ready);
    modport sink   (input valid, cmd, time_ticks, output ready);
endinterface

// File: hw/rtl/adsr_out_if.sv
// Result channel: envelope amplitude and phase code.
interface adsr_out_if ();
    logic                         valid;
    logic                         ready;
    logic [adsr_pkg::LVL_W-1:0]   amplitude;
    logic [adsr_pkg::PHASE_W-1:0] phase;

    modport source (output valid, amplitude, phase, input ready);
    modport sink   (input valid, amplitude, phase, output ready);
endinterface

// File: hw/rtl/adsr_envelope_generator_core.sv
// ADSR envelope generator top level: note state, phase sequencer, output register.
//
//  Channel   Dir   Payload                    Handshake
//  i_req     in    cmd[1:0], time_ticks[TW]   valid/ready, beat when both high
//  o_env     out   amplitude[15:0], phase[1:0] valid/ready, beat when both high
//  i_cfg_*   in    idx[2:0], data[23:0]       write on i_cfg_we, no back-pressure
//
// Note on / note off beats leave the block idle; it is ready again next cycle.
// A sample request keeps ready low while it goes through classify, multiply, 16 divide
// steps, done and finish, and its result is presented once finish loads the output
// register; sustain and finished release skip the scale unit and go straight to finish.
// Reset is synchronous, active low: register defaults restored, gate cleared.
// A stalled result waits in the output register; a new request is still taken and only
// its finish step waits for the register to free up.
module adsr_envelope_generator_core #(
    parameter int TIME_WIDTH = adsr_pkg::TIME_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    adsr_in_if.sink                             i_req,
    adsr_out_if.source                          o_env,
    input  logic                                i_cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int CW = (TIME_WIDTH > adsr_pkg::DUR_W) ? TIME_WIDTH : adsr_pkg::DUR_W;

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CLASS = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    // How the quotient becomes the amplitude
    localparam logic [2:0] MODE_ATK    = 3'd0;
    localparam logic [2:0] MODE_UP     = 3'd1;
    localparam logic [2:0] MODE_DN     = 3'd2;
    localparam logic [2:0] MODE_REL    = 3'd3;
    localparam logic [2:0] MODE_DIRECT = 3'd4;

    adsr_pkg::t_cfg     cfg;
    adsr_pkg::t_md_req  md_req;
    adsr_pkg::t_md_rsp  md_rsp;

    logic [1:0]                     r_state;
    logic                           r_gate;
    logic [TIME_WIDTH-1:0]          r_on_time;
    logic [TIME_WIDTH-1:0]          r_off_time;
    logic [TIME_WIDTH-1:0]          r_diff;     // life or release age
    logic [2:0]                     r_mode;
    logic [adsr_pkg::LVL_W-1:0]     r_base;
    logic [adsr_pkg::PHASE_W-1:0]   r_phase;
    logic                           r_ovalid;
    logic [adsr_pkg::LVL_W-1:0]     r_amp;
    logic [adsr_pkg::PHASE_W-1:0]   r_ophase;

    logic                           in_beat;
    logic                           out_beat;
    logic                           fin_load;

    // Classification of the age against the duration registers
    logic [CW-1:0]                  age;
    logic [CW-1:0]                  atk_ext;
    logic [CW-1:0]                  dec_ext;
    logic [CW-1:0]                  rel_ext;
    logic [CW-1:0]                  dd;
    logic                           in_attack;
    logic                           in_decay;
    logic                           in_release;
    logic                           sus_up;
    logic                           need_div;
    logic [2:0]                     n_mode;
    logic [adsr_pkg::LVL_W-1:0]     n_base;
    logic [adsr_pkg::PHASE_W-1:0]   n_phase;
    logic [adsr_pkg::DUR_W-1:0]     md_x;
    logic [adsr_pkg::LVL_W-1:0]     md_y;
    logic [adsr_pkg::DUR_W-1:0]     md_div;
    logic [adsr_pkg::LVL_W-1:0]     fin_amp;

    adsr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    adsr_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign in_beat     = i_req.valid && (r_state == S_IDLE);
    assign out_beat    = r_ovalid && o_env.ready;
    assign fin_load    = (r_state == S_FIN) && (!r_ovalid || o_env.ready);

    always_comb begin
        age        = CW'(r_diff);
        atk_ext    = CW'(cfg.atk_ticks);
        dec_ext    = CW'(cfg.dec_ticks);
        rel_ext    = CW'(cfg.rel_ticks);
        dd         = age - atk_ext;
        in_attack  = age <= atk_ext;
        in_decay   = dd <= dec_ext;
        in_release = age < rel_ext;
        sus_up     = cfg.sus_lvl >= cfg.start_lvl;

        need_div = 1'b1;
        n_mode   = MODE_DIRECT;
        n_base   = cfg.start_lvl;
        n_phase  = adsr_pkg::PHASE_RELEASE;
        md_x     = '0;
        md_y     = '0;
        md_div   = cfg.atk_ticks;

        if (r_gate) begin
            if (in_attack) begin
                n_mode  = MODE_ATK;
                n_phase = adsr_pkg::PHASE_ATTACK;
                md_x    = age[adsr_pkg::DUR_W-1:0];
                md_y    = cfg.start_lvl;
                md_div  = cfg.atk_ticks;
            end else if (in_decay) begin
                n_mode  = sus_up ? MODE_UP : MODE_DN;
                n_phase = adsr_pkg::PHASE_DECAY;
                md_x    = dd[adsr_pkg::DUR_W-1:0];
                md_y    = sus_up ? (cfg.sus_lvl - cfg.start_lvl)
                                 : (cfg.start_lvl - cfg.sus_lvl);
                md_div  = cfg.dec_ticks;
            end else begin
                need_div = 1'b0;
                n_base   = cfg.sus_lvl;
                n_phase  = adsr_pkg::PHASE_SUSTAIN;
            end
        end else begin
            // Release always ramps down from the sustain level
            if (in_release) begin
                n_mode = MODE_REL;
                md_x   = adsr_pkg::DUR_W'(rel_ext - age);
                md_y   = cfg.sus_lvl;
                md_div = cfg.rel_ticks;
            end else begin
                need_div = 1'b0;
                n_base   = '0;
            end
        end
    end

    assign md_req.start = (r_state == S_CLASS) && need_div;
    assign md_req.x     = md_x;
    assign md_req.y     = md_y;
    assign md_req.div   = md_div;

    always_comb begin
        case (r_mode)
            MODE_ATK: fin_amp = md_rsp.quo;
            MODE_UP:  fin_amp = r_base + md_rsp.quo;
            MODE_DN:  fin_amp = r_base - md_rsp.quo;
            MODE_REL: fin_amp = (md_rsp.quo <= adsr_pkg::FLOOR_LEVEL) ? '0 : md_rsp.quo;
            default:  fin_amp = r_base;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_gate     <= 1'b0;
            r_on_time  <= '0;
            r_off_time <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        case (i_req.cmd)
                            adsr_pkg::CMD_SAMPLE: r_state <= S_CLASS;
                            adsr_pkg::CMD_NOTE_ON: begin
                                r_on_time <= i_req.time_ticks;
                                r_gate    <= 1'b1;
                            end
                            adsr_pkg::CMD_NOTE_OFF: begin
                                r_off_time <= i_req.time_ticks;
                                r_gate     <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLASS: r_state <= need_div ? S_WAIT : S_FIN;
                S_WAIT: begin
                    if (md_rsp.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (fin_load) begin
                r_ovalid <= 1'b1;
            end else if (out_beat) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_diff <= i_req.time_ticks - (r_gate ? r_on_time : r_off_time);
        end
        if (r_state == S_CLASS) begin
            r_mode  <= need_div ? n_mode : MODE_DIRECT;
            r_base  <= n_base;
            r_phase <= n_phase;
        end
        if (fin_load) begin
            r_amp    <= fin_amp;
            r_ophase <= r_phase;
        end
    end

    assign o_env.valid     = r_ovalid;
    assign o_env.amplitude = r_amp;
    assign o_env.phase     = r_ophase;
endmodule

// File: hw/rtl/adsr_cfg.sv
// Configuration registers, cleaned up on write (zero duration -> 1, level capped).
module adsr_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]      i_idx,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]     i_data,
    output adsr_pkg::t_cfg                      o_cfg
);
    adsr_pkg::t_cfg                 r_cfg;
    logic [adsr_pkg::DUR_W-1:0]     dur_val;
    logic [adsr_pkg::LVL_W-1:0]     lvl_raw;
    logic [adsr_pkg::LVL_W-1:0]     lvl_val;

    always_comb begin
        dur_val = (i_data == '0) ? adsr_pkg::DUR_W'(1) : i_data;
        lvl_raw = i_data[adsr_pkg::LVL_W-1:0];
        lvl_val = (lvl_raw > adsr_pkg::FULL_LEVEL) ? adsr_pkg::FULL_LEVEL : lvl_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.atk_ticks <= adsr_pkg::RST_ATTACK;
            r_cfg.dec_ticks <= adsr_pkg::RST_DECAY;
            r_cfg.rel_ticks <= adsr_pkg::RST_RELEASE;
            r_cfg.start_lvl <= adsr_pkg::RST_START;
            r_cfg.sus_lvl   <= adsr_pkg::RST_SUSTAIN;
        end else if (i_we) begin
            case (i_idx)
                adsr_pkg::REG_ATTACK:  r_cfg.atk_ticks <= dur_val;
                adsr_pkg::REG_DECAY:   r_cfg.dec_ticks <= dur_val;
                adsr_pkg::REG_RELEASE: r_cfg.rel_ticks <= dur_val;
                adsr_pkg::REG_START:   r_cfg.start_lvl <= lvl_val;
                adsr_pkg::REG_SUSTAIN: r_cfg.sus_lvl   <= lvl_val;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// File: hw/rtl/adsr_muldiv.sv
// Shared scale unit: floor(x * y / div), one multiply then a 16-step restoring divide.
module adsr_muldiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  adsr_pkg::t_md_req   i_req,
    output adsr_pkg::t_md_rsp   o_rsp
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam int         CNT_W  = $clog2(adsr_pkg::QUO_W);

    logic [1:0]                     r_state;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_done;
    logic [adsr_pkg::DUR_W-1:0]     r_x;
    logic [adsr_pkg::LVL_W-1:0]     r_y;
    logic [adsr_pkg::DUR_W-1:0]     r_div;
    logic [adsr_pkg::DUR_W-1:0]     r_rem;
    logic [adsr_pkg::QUO_W-1:0]     r_quo;

    logic [adsr_pkg::PROD_W-1:0]    prod;
    logic [adsr_pkg::DUR_W:0]       trial;
    logic                           fits;

    always_comb begin
        prod  = adsr_pkg::PROD_W'(r_x) * adsr_pkg::PROD_W'(r_y);
        trial = {r_rem, r_quo[adsr_pkg::QUO_W-1]};
        fits  = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(adsr_pkg::QUO_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath; quotient fits in 16 bits, so the upper product bits seed the remainder.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.start) begin
            r_x   <= i_req.x;
            r_y   <= i_req.y;
            r_div <= i_req.div;
        end
        if (r_state == S_MUL) begin
            r_rem <= prod[adsr_pkg::PROD_W-1:adsr_pkg::QUO_W];
            r_quo <= prod[adsr_pkg::QUO_W-1:0];
        end else if (r_state == S_DIV) begin
            r_rem <= fits ? adsr_pkg::DUR_W'(trial - {1'b0, r_div})
                          : trial[adsr_pkg::DUR_W-1:0];
            r_quo <= {r_quo[adsr_pkg::QUO_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
